FILE: rtl/multi_cycle_deep_sleep_sequencer_top_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef MULTI_CYCLE_DEEP_SLEEP_SEQUENCER_TOP_MACROS_SVH
`define MULTI_CYCLE_DEEP_SLEEP_SEQUENCER_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define MCDS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define MCDS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mcds_pkg.sv
// Types, constants and lookup functions for the deep sleep sequencer.
package mcds_pkg;

   localparam int unsigned MS_PER_MINUTE = 60000;
   localparam int unsigned HOLD_MINUTES  = 5;

   localparam int unsigned AWAKE_W  = 20;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned US_W     = 32;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 32;

   localparam logic [AWAKE_W-1:0] AWAKE_MAX = '1;
   localparam logic [AWAKE_W-1:0] HOLD_MS   = AWAKE_W'(HOLD_MINUTES * MS_PER_MINUTE);

   localparam logic [US_W-1:0] US_5MIN  = 32'd300000000;
   localparam logic [US_W-1:0] US_30MIN = 32'd1800000000;
   localparam logic [US_W-1:0] US_1H    = 32'd3600000000;

   typedef enum logic [1:0] {
      MODE_WAKE      = 2'd0,
      MODE_TICK      = 2'd1,
      MODE_SLEEP_REQ = 2'd2,
      MODE_HOLD      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      WAKE_MANUAL = 2'd0,
      WAKE_AUTO   = 2'd1,
      WAKE_SCHED  = 2'd2
   } wake_kind_type;

   localparam logic [1:0] CAUSE_MANUAL = 2'd0;

   localparam logic KIND_AUTO  = 1'b0;
   localparam logic KIND_SCHED = 1'b1;

   // Sleep length codes
   localparam logic [3:0] LEN_5MIN  = 4'd0;
   localparam logic [3:0] LEN_30MIN = 4'd1;
   localparam logic [3:0] LEN_1H    = 4'd2;
   localparam logic [3:0] LEN_3H    = 4'd3;
   localparam logic [3:0] LEN_6H    = 4'd4;
   localparam logic [3:0] LEN_8H    = 4'd5;
   localparam logic [3:0] LEN_12H   = 4'd6;
   localparam logic [3:0] LEN_16H   = 4'd7;
   localparam logic [3:0] LEN_20H   = 4'd8;
   localparam logic [3:0] LEN_24H   = 4'd9;

   // Awake time codes
   localparam logic [2:0] ON_ZERO     = 3'd0;
   localparam logic [2:0] ON_1MIN     = 3'd1;
   localparam logic [2:0] ON_2MIN     = 3'd2;
   localparam logic [2:0] ON_5MIN     = 3'd3;
   localparam logic [2:0] ON_15MIN    = 3'd4;
   localparam logic [2:0] ON_INFINITE = 3'd5;

   // Register indexes
   localparam logic [1:0] REG_ENABLE   = 2'd0;
   localparam logic [1:0] REG_ON_CODE  = 2'd1;
   localparam logic [1:0] REG_OFF_CODE = 2'd2;

   localparam logic [2:0] ON_CODE_RESET  = ON_INFINITE;
   localparam logic [3:0] OFF_CODE_RESET = LEN_8H;

   // Number of extra one-hour sleeps in a chain
   function automatic logic [COUNT_W-1:0] chain_target(input logic [3:0] len);
      logic [COUNT_W-1:0] t;
      case (len)
         LEN_3H:  t = COUNT_W'(2);
         LEN_6H:  t = COUNT_W'(5);
         LEN_8H:  t = COUNT_W'(7);
         LEN_12H: t = COUNT_W'(11);
         LEN_16H: t = COUNT_W'(15);
         LEN_20H: t = COUNT_W'(19);
         LEN_24H: t = COUNT_W'(23);
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [AWAKE_W-1:0] on_threshold(input logic [2:0] code);
      logic [AWAKE_W-1:0] t;
      case (code)
         ON_1MIN:  t = AWAKE_W'(1 * MS_PER_MINUTE);
         ON_2MIN:  t = AWAKE_W'(2 * MS_PER_MINUTE);
         ON_5MIN:  t = AWAKE_W'(5 * MS_PER_MINUTE);
         ON_15MIN: t = AWAKE_W'(15 * MS_PER_MINUTE);
         default:  t = '0;
      endcase
      return t;
   endfunction

endpackage

FILE: rtl/multi_cycle_deep_sleep_sequencer_top.sv
// Deep sleep sequencer: splits long sleeps into chained one-hour sleeps.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     mode, wake_cause, sleep_length
//   rsp      out        rsp_valid/stall     sleep_now, sleep_us, radio_on_wake,
//                                            event_kind, wake_kind
//   csr      in/out     APB psel/penable    paddr, pwdata, prdata
//
// One item per cycle sustained while the result is not stalled; a request passes
// through the input register and then the result register on its way to the result.
// State update and result decision are one compare-and-update pass per item.
// Reset is synchronous; the block takes items in the first cycle after reset.
// A stalled result holds; the input register keeps taking items as long as
// the result register drains.
`include "multi_cycle_deep_sleep_sequencer_top_macros.svh"

module multi_cycle_deep_sleep_sequencer_top
   import mcds_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [1:0]          req_wake_cause,
   input  logic [3:0]          req_sleep_length,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_sleep_now,
   output logic [US_W-1:0]     rsp_sleep_us,
   output logic                rsp_radio_on_wake,
   output logic                rsp_event_kind,
   output logic [1:0]          rsp_wake_kind,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   // Configuration
   logic                cfg_enable_ff;
   logic [2:0]          cfg_on_code_ff;
   logic [3:0]          cfg_off_code_ff;
   logic                csr_write;
   logic [1:0]          csr_index;

   // Input register
   logic                in_valid_ff;
   mode_type            in_mode_ff;
   logic [1:0]          in_cause_ff;
   logic [3:0]          in_len_ff;

   // Result register
   logic                rsp_valid_ff;
   logic                rsp_sleep_now_ff;
   logic [US_W-1:0]     rsp_sleep_us_ff;
   logic                rsp_radio_ff;
   logic                rsp_kind_ff;
   wake_kind_type       rsp_wake_kind_ff;

   // Sequencer state
   logic [COUNT_W-1:0]  sleep_cnt_ff,   sleep_cnt_in;
   logic [COUNT_W-1:0]  target_ff,      target_in;
   logic                chain_ff,       chain_in;
   logic [US_W-1:0]     stored_us_ff,   stored_us_in;
   logic                radio_ff,       radio_in;
   logic                kind_ff,        kind_in;
   wake_kind_type       wake_kind_ff,   wake_kind_in;
   logic [AWAKE_W-1:0]  awake_ff,       awake_in;
   logic                hold_ff,        hold_in;
   logic                issued_ff,      issued_in;

   logic                out_free;
   logic                advance;
   logic [COUNT_W-1:0]  cnt_wrap;
   logic [AWAKE_W-1:0]  awake_tick;
   logic [AWAKE_W-1:0]  awake_cur;
   logic                hold_over;
   logic                expired;
   logic                do_plan;
   logic [3:0]          plan_len;
   logic                plan_kind;
   logic                slp;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_enable_ff   <= 1'b0;
         cfg_on_code_ff  <= ON_CODE_RESET;
         cfg_off_code_ff <= OFF_CODE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ENABLE:   cfg_enable_ff   <= csr_pwdata[0];
            REG_ON_CODE:  cfg_on_code_ff  <= csr_pwdata[2:0];
            REG_OFF_CODE: cfg_off_code_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ENABLE:   csr_prdata = CSR_DW'(cfg_enable_ff);
         REG_ON_CODE:  csr_prdata = CSR_DW'(cfg_on_code_ff);
         REG_OFF_CODE: csr_prdata = CSR_DW'(cfg_off_code_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff  <= mode_type'(req_mode);
         in_cause_ff <= req_wake_cause;
         in_len_ff   <= req_sleep_length;
      end
   end

   // -------------------------------------------------------- next state
   assign cnt_wrap   = sleep_cnt_ff + COUNT_W'(1);
   assign awake_tick = (awake_ff != AWAKE_MAX) ? awake_ff + AWAKE_W'(1) : awake_ff;
   assign awake_cur  = (in_mode_ff == MODE_TICK) ? awake_tick : awake_ff;
   assign hold_over  = awake_cur >= HOLD_MS;

   always_comb begin
      if (cfg_on_code_ff == ON_INFINITE) begin
         expired = 1'b0;
      end else if (cfg_on_code_ff inside {[ON_1MIN:ON_15MIN]}) begin
         expired = awake_cur >= on_threshold(cfg_on_code_ff);
      end else begin
         expired = 1'b1;
      end
      // an active hold blocks sleep until it runs out
      if (hold_ff && !hold_over) begin
         expired = 1'b0;
      end
   end

   always_comb begin
      sleep_cnt_in = sleep_cnt_ff;
      target_in    = target_ff;
      chain_in     = chain_ff;
      stored_us_in = stored_us_ff;
      radio_in     = radio_ff;
      kind_in      = kind_ff;
      wake_kind_in = wake_kind_ff;
      awake_in     = awake_ff;
      hold_in      = hold_ff;
      issued_in    = issued_ff;
      slp          = 1'b0;
      do_plan      = 1'b0;
      plan_len     = in_len_ff;
      plan_kind    = KIND_AUTO;

      case (in_mode_ff)
         MODE_WAKE: begin
            awake_in     = '0;
            issued_in    = 1'b0;
            hold_in      = (in_cause_ff == CAUSE_MANUAL);
            wake_kind_in = (in_cause_ff == CAUSE_MANUAL) ? WAKE_MANUAL : WAKE_AUTO;
            if (chain_ff) begin
               // advance the chain; past the target it ends
               if (cnt_wrap > target_ff) begin
                  chain_in     = 1'b0;
                  sleep_cnt_in = '0;
               end else begin
                  sleep_cnt_in = cnt_wrap;
               end
               if (sleep_cnt_in == '0) begin
                  target_in = '0;
                  if (wake_kind_in == WAKE_AUTO) begin
                     wake_kind_in = WAKE_SCHED;
                  end
               end else begin
                  radio_in  = (sleep_cnt_in == target_ff);
                  issued_in = 1'b1;
                  slp       = 1'b1;
               end
            end
         end
         MODE_TICK: begin
            awake_in = awake_tick;
            if (cfg_enable_ff && !issued_ff && expired) begin
               do_plan   = 1'b1;
               plan_len  = cfg_off_code_ff;
               plan_kind = KIND_AUTO;
            end
         end
         MODE_SLEEP_REQ: begin
            if (cfg_enable_ff && !issued_ff) begin
               if (!hold_ff || hold_over) begin
                  do_plan   = 1'b1;
                  plan_len  = in_len_ff;
                  plan_kind = KIND_SCHED;
               end else if (expired) begin
                  do_plan   = 1'b1;
                  plan_len  = cfg_off_code_ff;
                  plan_kind = KIND_AUTO;
               end
            end
         end
         MODE_HOLD: begin
            hold_in  = 1'b1;
            awake_in = '0;
         end
         default: ;
      endcase

      if (do_plan) begin
         slp          = 1'b1;
         issued_in    = 1'b1;
         sleep_cnt_in = '0;
         target_in    = chain_target(plan_len);
         stored_us_in = US_1H;
         kind_in      = plan_kind;
         radio_in     = 1'b0;
         chain_in     = 1'b1;
         case (plan_len)
            LEN_5MIN: begin
               stored_us_in = US_5MIN;
               radio_in     = 1'b1;
            end
            LEN_30MIN: begin
               stored_us_in = US_30MIN;
               radio_in     = 1'b1;
            end
            LEN_1H: begin
               radio_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sleep_cnt_ff <= '0;
         target_ff    <= '0;
         chain_ff     <= 1'b0;
         stored_us_ff <= '0;
         radio_ff     <= 1'b1;
         kind_ff      <= KIND_AUTO;
         wake_kind_ff <= WAKE_AUTO;
         awake_ff     <= '0;
         hold_ff      <= 1'b0;
         issued_ff    <= 1'b0;
      end else if (advance) begin
         sleep_cnt_ff <= sleep_cnt_in;
         target_ff    <= target_in;
         chain_ff     <= chain_in;
         stored_us_ff <= stored_us_in;
         radio_ff     <= radio_in;
         kind_ff      <= kind_in;
         wake_kind_ff <= wake_kind_in;
         awake_ff     <= awake_in;
         hold_ff      <= hold_in;
         issued_ff    <= issued_in;
      end
   end

   // ---------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sleep_now_ff <= slp;
         rsp_sleep_us_ff  <= slp ? stored_us_in : '0;
         rsp_radio_ff     <= radio_in;
         rsp_kind_ff      <= kind_in;
         rsp_wake_kind_ff <= wake_kind_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sleep_now     = rsp_sleep_now_ff;
   assign rsp_sleep_us      = rsp_sleep_us_ff;
   assign rsp_radio_on_wake = rsp_radio_ff;
   assign rsp_event_kind    = rsp_kind_ff;
   assign rsp_wake_kind     = rsp_wake_kind_ff;

   // ------------------------------------------------------- assertions
   `MCDS_ASSERT_IMPL(a_sleep_has_length, rsp_valid_ff && rsp_sleep_now_ff, rsp_sleep_us_ff != '0, "sleep result without a length")
   `MCDS_ASSERT_IMPL(a_awake_no_length, rsp_valid_ff && !rsp_sleep_now_ff, rsp_sleep_us_ff == '0, "length given without sleep")
   `MCDS_ASSERT_IMPL(a_chain_in_range, chain_ff, sleep_cnt_ff <= target_ff, "chain counter past its target")
   `MCDS_ASSERT_IMPL(a_issued_clears_on_wake, $fell(issued_ff) && !$past(reset), $past(advance && in_mode_ff == MODE_WAKE), "sleep lockout dropped without a wake")

endmodule

FILE: test/multi_cycle_deep_sleep_sequencer_top_test.sv
// Testbench for the deep sleep sequencer: predicts every result and checks each transfer in order.
module multi_cycle_deep_sleep_sequencer_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mcds_pkg::*;

   localparam logic [1:0] CAUSE_TIMER = 2'd1;
   localparam logic [1:0] CAUSE_OTHER = 2'd2;
   localparam logic [1:0] CAUSE_UNDEF = 2'd3;
   localparam logic [2:0] ON_UNDEF_LO = 3'd6;
   localparam logic [2:0] ON_UNDEF_HI = 3'd7;
   localparam logic [3:0] LEN_UNDEF_LO = 4'd10;
   localparam logic [3:0] LEN_UNDEF_HI = 4'd15;

   localparam int unsigned HOLD_TICKS = HOLD_MINUTES * MS_PER_MINUTE;
   localparam int SETTLE_CYCLES = 4;
   localparam int RSP_HOLD_CYCLES = 60;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ROUND_ITEMS = 66;

   typedef struct {
      logic            sleep_now;
      logic [US_W-1:0] sleep_us;
      logic            radio_on;
      logic            sched;
      wake_kind_type   wake;
   } sleep_decision_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_mode = '0;
   logic [1:0]        req_wake_cause = '0;
   logic [3:0]        req_sleep_length = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_sleep_now;
   logic [US_W-1:0]   rsp_sleep_us;
   logic              rsp_radio_on_wake;
   logic              rsp_event_kind;
   logic [1:0]        rsp_wake_kind;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // Shadow registers and sequencer state
   logic                pm_enable = 1'b0;
   logic [2:0]          on_code = ON_CODE_RESET;
   logic [3:0]          off_code = OFF_CODE_RESET;
   logic [COUNT_W-1:0]  hop_count = '0;
   logic [COUNT_W-1:0]  hop_target = '0;
   logic                chain_armed = 1'b0;
   logic [US_W-1:0]     planned_us = '0;
   logic                radio_next = 1'b1;
   logic                planned_sched = KIND_AUTO;
   wake_kind_type       wake_state = WAKE_AUTO;
   logic [AWAKE_W-1:0]  awake_ticks = '0;
   logic                hold_active = 1'b0;
   logic                sleep_latched = 1'b0;

   sleep_decision_type expected_decisions[$];
   int error_count = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit rsp_hold_start = 1'b0;
   int rsp_hold_left = 0;

   multi_cycle_deep_sleep_sequencer_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_wake_cause    (req_wake_cause),
      .req_sleep_length  (req_sleep_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sleep_now     (rsp_sleep_now),
      .rsp_sleep_us      (rsp_sleep_us),
      .rsp_radio_on_wake (rsp_radio_on_wake),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_wake_kind     (rsp_wake_kind),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [COUNT_W-1:0] extra_hours(input logic [3:0] len);
      case (len)
         LEN_3H:  return COUNT_W'(2);
         LEN_6H:  return COUNT_W'(5);
         LEN_8H:  return COUNT_W'(7);
         LEN_12H: return COUNT_W'(11);
         LEN_16H: return COUNT_W'(15);
         LEN_20H: return COUNT_W'(19);
         LEN_24H: return COUNT_W'(23);
         default: return '0;
      endcase
   endfunction

   function automatic int unsigned on_limit_ms(input logic [2:0] code);
      case (code)
         ON_1MIN:  return 1 * MS_PER_MINUTE;
         ON_2MIN:  return 2 * MS_PER_MINUTE;
         ON_5MIN:  return 5 * MS_PER_MINUTE;
         ON_15MIN: return 15 * MS_PER_MINUTE;
         default:  return 0;
      endcase
   endfunction

   function automatic bit hold_elapsed();
      return awake_ticks >= HOLD_TICKS;
   endfunction

   function automatic void arm_sleep_plan(input logic [3:0] len, input logic kind);
      hop_count = '0;
      hop_target = '0;
      planned_us = US_1H;
      planned_sched = kind;
      radio_next = 1'b0;
      case (len)
         LEN_5MIN: begin
            planned_us = US_5MIN;
            radio_next = 1'b1;
         end
         LEN_30MIN: begin
            planned_us = US_30MIN;
            radio_next = 1'b1;
         end
         LEN_1H: radio_next = 1'b1;
         default: hop_target = extra_hours(len);
      endcase
      chain_armed = 1'b1;
   endfunction

   function automatic bit awake_time_up();
      bit up;
      if (on_code == ON_INFINITE) up = 1'b0;
      else if (on_code >= ON_1MIN && on_code <= ON_15MIN) up = awake_ticks >= on_limit_ms(on_code);
      else up = 1'b1;
      if (hold_active) up = up && hold_elapsed();
      return up;
   endfunction

   function automatic bit try_sleep(input bit sched, input logic [3:0] len);
      if (!pm_enable || sleep_latched) return 1'b0;
      if (sched && (!hold_active || hold_elapsed())) begin
         sleep_latched = 1'b1;
         arm_sleep_plan(len, KIND_SCHED);
         return 1'b1;
      end
      if (awake_time_up()) begin
         sleep_latched = 1'b1;
         arm_sleep_plan(off_code, KIND_AUTO);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit wake_up(input logic [1:0] cause);
      awake_ticks = '0;
      sleep_latched = 1'b0;
      hold_active = (cause == CAUSE_MANUAL);
      wake_state = (cause == CAUSE_MANUAL) ? WAKE_MANUAL : WAKE_AUTO;
      if (!chain_armed) return 1'b0;
      hop_count = hop_count + 1'b1;
      if (hop_count > hop_target) begin
         chain_armed = 1'b0;
         hop_count = '0;
      end
      if (hop_count == '0) begin
         hop_target = '0;
         if (wake_state == WAKE_AUTO) wake_state = WAKE_SCHED;
         return 1'b0;
      end
      // radio comes back only for the final hour of the chain
      radio_next = (hop_count == hop_target);
      sleep_latched = 1'b1;
      return 1'b1;
   endfunction

   function automatic void predict_sleep_decision(input mode_type m, input logic [1:0] cause,
                                                  input logic [3:0] len);
      sleep_decision_type d;
      bit slept;
      slept = 1'b0;
      case (m)
         MODE_WAKE: slept = wake_up(cause);
         MODE_TICK: begin
            if (awake_ticks != AWAKE_MAX) awake_ticks = awake_ticks + 1'b1;
            slept = try_sleep(1'b0, '0);
         end
         MODE_SLEEP_REQ: slept = try_sleep(1'b1, len);
         default: begin
            hold_active = 1'b1;
            awake_ticks = '0;
         end
      endcase
      d.sleep_now = slept;
      d.sleep_us = slept ? planned_us : '0;
      d.radio_on = radio_next;
      d.sched = planned_sched;
      d.wake = wake_state;
      expected_decisions.push_back(d);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      sleep_decision_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_decisions.size() == 0) begin
            report_mismatch("result with nothing pending", 32'd0, 32'd0);
         end else begin
            want = expected_decisions.pop_front();
            if (rsp_sleep_now !== want.sleep_now)
               report_mismatch("sleep_now", 32'(rsp_sleep_now), 32'(want.sleep_now));
            if (rsp_sleep_us !== want.sleep_us)
               report_mismatch("sleep_us", rsp_sleep_us, want.sleep_us);
            if (rsp_radio_on_wake !== want.radio_on)
               report_mismatch("radio_on_wake", 32'(rsp_radio_on_wake), 32'(want.radio_on));
            if (rsp_event_kind !== want.sched)
               report_mismatch("event_kind", 32'(rsp_event_kind), 32'(want.sched));
            if (rsp_wake_kind !== want.wake)
               report_mismatch("wake_kind", 32'(rsp_wake_kind), 32'(want.wake));
         end
      end
   end

   // Result stall: a long hold-off when asked, random stalls otherwise
   always @(posedge clock) begin
      if (rsp_hold_start) begin
         rsp_hold_left = RSP_HOLD_CYCLES;
         rsp_hold_start = 1'b0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multi_cycle_deep_sleep_sequencer_top_test failed");
         $finish;
      end
   end

   task automatic send_item(input mode_type m, input logic [1:0] cause, input logic [3:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_wake_cause <= cause;
      req_sleep_length <= len;
      do @(posedge clock); while (req_stall);
      predict_sleep_decision(m, cause, len);
      items_sent++;
   endtask

   // Drop valid and wait until every pending result has been taken
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [CSR_DW-1:0] value);
      settle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_ENABLE:  pm_enable = value[0];
         REG_ON_CODE: on_code = value[2:0];
         default:     off_code = value[3:0];
      endcase
   endtask

   // Keep waking until the current sleep chain has run out
   task automatic follow_chain(input bit noisy);
      int n;
      while (chain_armed) begin
         n = noisy ? $urandom_range(99) : 0;
         if (n < 80) send_item(MODE_WAKE, CAUSE_TIMER, 4'($urandom));
         else if (n < 87) send_item(MODE_WAKE, 2'($urandom), 4'($urandom));
         else if (n < 94) send_item(MODE_TICK, 2'($urandom), 4'($urandom));
         else send_item(MODE_HOLD, 2'($urandom), 4'($urandom));
      end
   endtask

   task automatic random_episode();
      int pick;
      logic [3:0] len;
      pick = $urandom_range(99);
      len = ($urandom_range(9) < 8) ? 4'($urandom_range(9)) : 4'($urandom_range(10, 15));
      if (pick < 50) begin
         send_item(MODE_WAKE, 2'($urandom_range(1, 3)), 4'($urandom));
         send_item(MODE_SLEEP_REQ, 2'($urandom), len);
         follow_chain(1'b1);
      end else if (pick < 70) begin
         repeat ($urandom_range(1, 8)) send_item(MODE_TICK, 2'($urandom), 4'($urandom));
      end else if (pick < 85) begin
         send_item(MODE_WAKE, 2'($urandom), 4'($urandom));
      end else if (pick < 95) begin
         send_item(MODE_HOLD, 2'($urandom), 4'($urandom));
      end else begin
         send_item(MODE_SLEEP_REQ, 2'($urandom), 4'($urandom));
      end
   endtask

   task automatic test_directed();
      // disabled: nothing sleeps, undefined cause counts as automatic
      send_item(MODE_TICK, CAUSE_UNDEF, LEN_UNDEF_HI);
      send_item(MODE_SLEEP_REQ, CAUSE_MANUAL, LEN_24H);
      send_item(MODE_HOLD, CAUSE_OTHER, LEN_5MIN);
      send_item(MODE_WAKE, CAUSE_UNDEF, LEN_5MIN);
      set_reg(REG_ENABLE, 32'd1);
      // three-hour chain ends in a scheduled wake
      send_item(MODE_SLEEP_REQ, CAUSE_TIMER, LEN_3H);
      repeat (3) send_item(MODE_WAKE, CAUSE_TIMER, LEN_5MIN);
      send_item(MODE_SLEEP_REQ, CAUSE_MANUAL, LEN_5MIN);
      send_item(MODE_WAKE, CAUSE_OTHER, LEN_5MIN);
      send_item(MODE_SLEEP_REQ, CAUSE_MANUAL, LEN_UNDEF_HI);
      send_item(MODE_WAKE, CAUSE_TIMER, LEN_5MIN);
      // manual wake holds off a request
      send_item(MODE_WAKE, CAUSE_MANUAL, LEN_5MIN);
      send_item(MODE_SLEEP_REQ, CAUSE_MANUAL, LEN_30MIN);
      send_item(MODE_HOLD, CAUSE_MANUAL, LEN_5MIN);
      send_item(MODE_TICK, CAUSE_MANUAL, LEN_5MIN);
      // manual wake inside a chain still advances it
      send_item(MODE_WAKE, CAUSE_OTHER, LEN_5MIN);
      send_item(MODE_SLEEP_REQ, CAUSE_TIMER, LEN_6H);
      send_item(MODE_WAKE, CAUSE_MANUAL, LEN_5MIN);
      follow_chain(1'b0);
      set_reg(REG_ON_CODE, CSR_DW'(ON_ZERO));
      set_reg(REG_OFF_CODE, CSR_DW'(LEN_1H));
      send_item(MODE_WAKE, CAUSE_TIMER, LEN_5MIN);
      repeat (2) send_item(MODE_TICK, CAUSE_TIMER, LEN_5MIN);
      send_item(MODE_WAKE, CAUSE_TIMER, LEN_5MIN);
      // undefined awake and sleep codes
      set_reg(REG_ON_CODE, CSR_DW'(ON_UNDEF_HI));
      set_reg(REG_OFF_CODE, CSR_DW'(LEN_UNDEF_HI));
      send_item(MODE_TICK, CAUSE_TIMER, LEN_5MIN);
      send_item(MODE_WAKE, CAUSE_TIMER, LEN_1H);
      settle();
   endtask

   task automatic test_backpressure();
      int start;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_start = 1'b1;
      start = items_sent;
      while (items_sent - start < 40) random_episode();
      settle();
      start = items_sent;
      while (items_sent - start < 10) random_episode();
      settle();
   endtask

   task automatic test_hold_window();
      set_reg(REG_ENABLE, 32'd1);
      set_reg(REG_ON_CODE, CSR_DW'(ON_ZERO));
      follow_chain(1'b0);
      // a manual wake blocks both automatic and scheduled sleep
      send_item(MODE_WAKE, CAUSE_MANUAL, LEN_5MIN);
      repeat (4) send_item(MODE_TICK, CAUSE_TIMER, LEN_5MIN);
      send_item(MODE_SLEEP_REQ, CAUSE_TIMER, LEN_1H);
      // a hold-off request starts the hold after an automatic wake
      send_item(MODE_WAKE, CAUSE_OTHER, LEN_5MIN);
      send_item(MODE_HOLD, CAUSE_TIMER, LEN_5MIN);
      send_item(MODE_TICK, CAUSE_TIMER, LEN_5MIN);
      send_item(MODE_SLEEP_REQ, CAUSE_TIMER, LEN_1H);
      follow_chain(1'b0);
      settle();
   endtask

   task automatic test_awake_limits();
      logic [2:0] codes[4];
      codes = '{ON_1MIN, ON_2MIN, ON_5MIN, ON_15MIN};
      set_reg(REG_ENABLE, 32'd1);
      set_reg(REG_ON_CODE, CSR_DW'(ON_INFINITE));
      follow_chain(1'b0);
      send_item(MODE_WAKE, CAUSE_TIMER, LEN_5MIN);
      repeat (3) send_item(MODE_TICK, CAUSE_TIMER, LEN_5MIN);
      // a few ticks stay short of every finite limit
      foreach (codes[i]) begin
         set_reg(REG_ON_CODE, CSR_DW'(codes[i]));
         send_item(MODE_TICK, CAUSE_TIMER, LEN_5MIN);
      end
      // undefined awake code acts as zero awake time
      set_reg(REG_ON_CODE, CSR_DW'(ON_UNDEF_LO));
      send_item(MODE_TICK, CAUSE_TIMER, LEN_5MIN);
      follow_chain(1'b0);
      settle();
   endtask

   task automatic test_random();
      int start;
      for (int r = 0; r < 8; r++) begin
         case (r % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         case (r)
            0: begin
               set_reg(REG_ENABLE, 32'd1);
               set_reg(REG_ON_CODE, CSR_DW'(ON_ZERO));
               set_reg(REG_OFF_CODE, CSR_DW'(LEN_24H));
            end
            1: begin
               set_reg(REG_ON_CODE, CSR_DW'(ON_UNDEF_HI));
               set_reg(REG_OFF_CODE, CSR_DW'(LEN_UNDEF_HI));
            end
            2: begin
               set_reg(REG_ENABLE, 32'd0);
               set_reg(REG_ON_CODE, CSR_DW'(ON_ZERO));
               set_reg(REG_OFF_CODE, CSR_DW'(LEN_5MIN));
            end
            3: begin
               set_reg(REG_ENABLE, 32'd1);
               set_reg(REG_ON_CODE, CSR_DW'(ON_UNDEF_LO));
               set_reg(REG_OFF_CODE, CSR_DW'(LEN_3H));
            end
            default: begin
               set_reg(REG_ENABLE, 32'($urandom_range(3) != 0));
               set_reg(REG_ON_CODE, 32'($urandom_range(7)));
               set_reg(REG_OFF_CODE, 32'($urandom_range(15)));
            end
         endcase
         start = items_sent;
         while (items_sent - start < ROUND_ITEMS) random_episode();
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      settle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_hold_window();
      test_awake_limits();
      test_random();
      settle();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_decisions.size() == 0) begin
         $display("multi_cycle_deep_sleep_sequencer_top_test passed");
      end else begin
         $display("multi_cycle_deep_sleep_sequencer_top_test failed");
      end
      $finish;
   end

endmodule
